>>> design/battery_monitor_frame_watchdog_defines.svh
// Assertion macros for the battery monitor frame watchdog.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef BATTERY_MONITOR_FRAME_WATCHDOG_DEFINES_SVH
`define BATTERY_MONITOR_FRAME_WATCHDOG_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define BMFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define BMFW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMFW_ASSERT(lbl, prop, msg)
`define BMFW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/bmfw_pkg.sv
// Shared types and constants for the battery monitor frame watchdog.
// No dependencies; imported by every module of the block.
package bmfw_pkg;

  localparam int FRAME_ID_W  = 11;
  localparam int NUM_BYTES   = 8;
  localparam int CODE_W      = 16;
  localparam int CNT_W       = 12;
  localparam int LIMIT_W     = 14;
  localparam int TIMEOUT_W   = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic [FRAME_ID_W-1:0] ID_UNIT0 = 11'h4F1;
  localparam logic [FRAME_ID_W-1:0] ID_UNIT1 = 11'h4F5;
  localparam logic [LIMIT_W-1:0]    CHARGE_LIMIT_ON = 14'd9998;

  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 8'd1;
  localparam logic [CODE_W-1:0]    RST_VMAX    = 16'd55050;
  localparam logic [CODE_W-1:0]    RST_VMIN    = 16'd39321;
  localparam logic [CODE_W-1:0]    RST_TMAX    = 16'd65535;
  localparam logic [CODE_W-1:0]    RST_TMIN    = 16'd0;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DUAL_MODE = 3'd0,
    CFG_TIMEOUT   = 3'd1,
    CFG_VMAX      = 3'd2,
    CFG_VMIN      = 3'd3,
    CFG_TMAX      = 3'd4,
    CFG_TMIN      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    action_t                             action;
    logic [FRAME_ID_W-1:0]               frame_id;
    logic [NUM_BYTES-1:0][7:0]           payload;   // payload[0] is byte0
  } item_t;

  typedef struct packed {
    logic                 dual_mode;
    logic [TIMEOUT_W-1:0] timeout_seconds;
    logic [CODE_W-1:0]    vmax_code;
    logic [CODE_W-1:0]    vmin_code;
    logic [CODE_W-1:0]    tmax_code;
    logic [CODE_W-1:0]    tmin_code;
  } cfg_t;

  // Declared highest field first so the packed value matches out_tdata.
  typedef struct packed {
    logic [CODE_W-1:0]  max_temp_out;
    logic [CODE_W-1:0]  min_temp_out;
    logic [CODE_W-1:0]  max_cell_out;
    logic [CODE_W-1:0]  min_cell_out;
    logic [LIMIT_W-1:0] charge_limit;
    logic               charge_allowed;
    logic               data_valid;
  } result_t;

endpackage

>>> design/bmfw_cfg_regs.sv
// Configuration register bank for the battery monitor frame watchdog.
// Depends on bmfw_pkg.
module bmfw_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bmfw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bmfw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bmfw_pkg::cfg_t                     cfg
);
  import bmfw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DUAL_MODE: cfg_nxt.dual_mode       = cfg_wdata[0];
        CFG_TIMEOUT:   cfg_nxt.timeout_seconds = cfg_wdata[TIMEOUT_W-1:0];
        CFG_VMAX:      cfg_nxt.vmax_code       = cfg_wdata[CODE_W-1:0];
        CFG_VMIN:      cfg_nxt.vmin_code       = cfg_wdata[CODE_W-1:0];
        CFG_TMAX:      cfg_nxt.tmax_code       = cfg_wdata[CODE_W-1:0];
        CFG_TMIN:      cfg_nxt.tmin_code       = cfg_wdata[CODE_W-1:0];
        default:       cfg_nxt = cfg_r;   // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dual_mode       <= 1'b0;
      cfg_r.timeout_seconds <= RST_TIMEOUT;
      cfg_r.vmax_code       <= RST_VMAX;
      cfg_r.vmin_code       <= RST_VMIN;
      cfg_r.tmax_code       <= RST_TMAX;
      cfg_r.tmin_code       <= RST_TMIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/bmfw_in_stage.sv
// Input register of the battery monitor frame watchdog.
// Depends on bmfw_pkg.
module bmfw_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmfw_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output bmfw_pkg::item_t item
);
  import bmfw_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Take a new transfer whenever the held item is empty or leaves this cycle.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> design/bmfw_core.sv
// Unit store, silence counters, aggregates and result logic of the watchdog.
// Depends on bmfw_pkg.
module bmfw_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bmfw_pkg::item_t   item,
  input  logic              go,
  input  bmfw_pkg::cfg_t    cfg,
  output bmfw_pkg::result_t res
);
  import bmfw_pkg::*;

  localparam int NUM_UNITS = 2;

  function automatic logic [CODE_W-1:0] min16(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CODE_W-1:0] max16(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [CODE_W-1:0] max_cell_r [NUM_UNITS];
  logic [CODE_W-1:0] min_cell_r [NUM_UNITS];
  logic [CODE_W-1:0] max_temp_r [NUM_UNITS];
  logic [CODE_W-1:0] min_temp_r [NUM_UNITS];
  logic [CNT_W-1:0]  cnt_r      [NUM_UNITS];

  logic [CODE_W-1:0] max_cell_nxt [NUM_UNITS];
  logic [CODE_W-1:0] min_cell_nxt [NUM_UNITS];
  logic [CODE_W-1:0] max_temp_nxt [NUM_UNITS];
  logic [CODE_W-1:0] min_temp_nxt [NUM_UNITS];
  logic [CNT_W-1:0]  cnt_nxt      [NUM_UNITS];
  logic [CNT_W-1:0]  cnt_dec      [NUM_UNITS];

  logic [CODE_W-1:0] agg_min_cell_r, agg_max_cell_r, agg_min_temp_r, agg_max_temp_r;
  logic [CODE_W-1:0] agg_min_cell_nxt, agg_max_cell_nxt;
  logic [CODE_W-1:0] agg_min_temp_nxt, agg_max_temp_nxt;

  logic              hit [NUM_UNITS];
  logic              tick;
  logic [CNT_W-1:0]  reload;
  logic              data_valid;
  logic              allowed;

  assign hit[0] = go && (item.action == ACT_FRAME) && (item.frame_id == ID_UNIT0);
  assign hit[1] = go && (item.action == ACT_FRAME) && (item.frame_id == ID_UNIT1);
  assign tick   = go && (item.action == ACT_TICK);

  // Ten times the timeout as 8x + 2x.
  assign reload = {1'b0, cfg.timeout_seconds, 3'b000} + {3'b000, cfg.timeout_seconds, 1'b0};

  always_comb begin
    for (int u = 0; u < NUM_UNITS; u++) begin
      cnt_dec[u] = cnt_r[u] - {{(CNT_W-1){1'b0}}, (cnt_r[u] != '0)};
      if (hit[u]) begin
        max_cell_nxt[u] = {item.payload[0], item.payload[1]};
        min_cell_nxt[u] = {item.payload[2], item.payload[3]};
        max_temp_nxt[u] = {item.payload[4], item.payload[5]};
        min_temp_nxt[u] = {item.payload[6], item.payload[7]};
        cnt_nxt[u]      = reload;
      end else begin
        max_cell_nxt[u] = max_cell_r[u];
        min_cell_nxt[u] = min_cell_r[u];
        max_temp_nxt[u] = max_temp_r[u];
        min_temp_nxt[u] = min_temp_r[u];
        cnt_nxt[u]      = tick ? cnt_dec[u] : cnt_r[u];
      end
    end
  end

  // Temperature codes fall as temperature rises, hence the swapped min/max.
  always_comb begin
    agg_min_cell_nxt = agg_min_cell_r;
    agg_max_cell_nxt = agg_max_cell_r;
    agg_min_temp_nxt = agg_min_temp_r;
    agg_max_temp_nxt = agg_max_temp_r;
    if (hit[0] || hit[1]) begin
      if (cfg.dual_mode) begin
        agg_min_cell_nxt = min16(min_cell_nxt[0], min_cell_nxt[1]);
        agg_max_cell_nxt = max16(max_cell_nxt[0], max_cell_nxt[1]);
        agg_min_temp_nxt = max16(min_temp_nxt[0], min_temp_nxt[1]);
        agg_max_temp_nxt = min16(max_temp_nxt[0], max_temp_nxt[1]);
      end else begin
        agg_min_cell_nxt = min_cell_nxt[0];
        agg_max_cell_nxt = max_cell_nxt[0];
        agg_min_temp_nxt = min_temp_nxt[0];
        agg_max_temp_nxt = max_temp_nxt[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < NUM_UNITS; u++) begin
        max_cell_r[u] <= '0;
        min_cell_r[u] <= '0;
        max_temp_r[u] <= '0;
        min_temp_r[u] <= '0;
        cnt_r[u]      <= '0;
      end
      agg_min_cell_r <= '0;
      agg_max_cell_r <= '0;
      agg_min_temp_r <= '0;
      agg_max_temp_r <= '0;
    end else begin
      for (int u = 0; u < NUM_UNITS; u++) begin
        max_cell_r[u] <= max_cell_nxt[u];
        min_cell_r[u] <= min_cell_nxt[u];
        max_temp_r[u] <= max_temp_nxt[u];
        min_temp_r[u] <= min_temp_nxt[u];
        cnt_r[u]      <= cnt_nxt[u];
      end
      agg_min_cell_r <= agg_min_cell_nxt;
      agg_max_cell_r <= agg_max_cell_nxt;
      agg_min_temp_r <= agg_min_temp_nxt;
      agg_max_temp_r <= agg_max_temp_nxt;
    end
  end

  // Result of a tick: judged on the counters after the decrement.
  assign data_valid = (cnt_dec[0] != '0) && (!cfg.dual_mode || (cnt_dec[1] != '0));
  assign allowed    = data_valid
                   && (agg_max_cell_r <= cfg.vmax_code)
                   && (agg_min_cell_r >= cfg.vmin_code)
                   && (agg_max_temp_r <= cfg.tmax_code)
                   && (agg_min_temp_r >= cfg.tmin_code);

  always_comb begin
    res.data_valid     = data_valid;
    res.charge_allowed = allowed;
    res.charge_limit   = allowed ? CHARGE_LIMIT_ON : '0;
    res.min_cell_out   = data_valid ? agg_min_cell_r : '0;
    res.max_cell_out   = data_valid ? agg_max_cell_r : '0;
    res.min_temp_out   = data_valid ? agg_min_temp_r : '0;
    res.max_temp_out   = data_valid ? agg_max_temp_r : '0;
  end

endmodule

>>> design/bmfw_out_stage.sv
// Result register of the battery monitor frame watchdog.
// Depends on bmfw_pkg.
module bmfw_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bmfw_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output bmfw_pkg::result_t out_res
);
  import bmfw_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> design/battery_monitor_frame_watchdog.sv
// Channel   Direction  Width (data/user)  Carries
// in_       slave      80 / 1             one frame or one 100 ms tick
// out_      master     80 / -             status after each tick
// cfg_      write      16, index 3 bits   six configuration registers
//
// One transfer is taken every cycle while results drain; the input register and
// the result register hold one item each, so a tick result passes through both
// before it shows on out_tvalid. Frames update state and give no result.
// rst_n is synchronous: it clears the unit store, counters, aggregates and both
// valid flags, and loads the configuration reset values; no clearing pass.
// A stalled result holds a tick in the input register, and that tick holds the
// input; frames keep flowing past the stalled result until a tick arrives.
//
// Top level of the battery monitor frame watchdog.
// Depends on bmfw_pkg and the defines header; instantiates the four sub-blocks.
`include "battery_monitor_frame_watchdog_defines.svh"

module battery_monitor_frame_watchdog (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata, lowest bit up: frame_id[10:0], byte0..byte7 (8 bits each), zero pad
  input  logic [bmfw_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: action (0 frame, 1 tick)
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata, lowest bit up: data_valid, charge_allowed, charge_limit[13:0],
  // min_cell_out, max_cell_out, min_temp_out, max_temp_out (16 bits each)
  output logic [bmfw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [bmfw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bmfw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bmfw_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_adv;
  logic    out_load;
  cfg_t    cfg;
  result_t core_res;
  result_t out_res;

  // Unpack the incoming transfer.
  always_comb begin
    in_item.action   = action_t'(in_tuser);
    in_item.frame_id = in_tdata[FRAME_ID_W-1:0];
    for (int k = 0; k < NUM_BYTES; k++) begin
      in_item.payload[k] = in_tdata[FRAME_ID_W + 8*k +: 8];
    end
  end

  // A frame always leaves the input register; a tick leaves only when the
  // result register is free or is being emptied this cycle.
  assign s1_adv   = s1_valid && ((s1_item.action == ACT_FRAME) || !out_tvalid || out_tready);
  assign out_load = s1_adv && (s1_item.action == ACT_TICK);

  bmfw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmfw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (s1_adv),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  bmfw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_item),
    .go    (s1_adv),
    .cfg   (cfg),
    .res   (core_res)
  );

  bmfw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .res       (core_res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = out_res;

  // Frames never load the result register.
  `BMFW_ASSERT(a_frame_no_result, (s1_valid && s1_item.action == ACT_FRAME) |-> !out_load, "frame produced a result")
  // Charge permission only comes with valid data and the full limit.
  `BMFW_ASSERT(a_allowed_needs_valid, out_tvalid && out_res.charge_allowed |-> (out_res.data_valid && out_res.charge_limit == CHARGE_LIMIT_ON), "charge allowed without valid data")
  // Reset leaves both registers empty and the input open.
  `BMFW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && in_tready), "registers not empty after reset")

endmodule

>>> dv/tb.sv
// Self-checking bench for battery_monitor_frame_watchdog: frame and tick transfers in,
// status transfers out, compared against an in-bench prediction of the watchdog.
// Depends on bmfw_pkg for port widths, identifiers, register indexes and the result layout.

// Prediction of the watchdog plus the queue of status transfers still owed by the block.
class status_predictor;
  bit        dual_mode;
  bit [7:0]  timeout_s;
  bit [15:0] vmax, vmin, tmax, tmin;

  bit [15:0] unit_maxc[2], unit_minc[2], unit_maxt[2], unit_mint[2];
  bit [11:0] silence[2];
  bit [15:0] agg_minc, agg_maxc, agg_mint, agg_maxt;

  bmfw_pkg::result_t expected_status[$];
  int errors;

  function new();
    dual_mode = 1'b0;
    timeout_s = bmfw_pkg::RST_TIMEOUT;
    vmax      = bmfw_pkg::RST_VMAX;
    vmin      = bmfw_pkg::RST_VMIN;
    tmax      = bmfw_pkg::RST_TMAX;
    tmin      = bmfw_pkg::RST_TMIN;
    for (int i = 0; i < 2; i++) begin
      unit_maxc[i] = '0;
      unit_minc[i] = '0;
      unit_maxt[i] = '0;
      unit_mint[i] = '0;
      silence[i]   = '0;
    end
    agg_minc = '0;
    agg_maxc = '0;
    agg_mint = '0;
    agg_maxt = '0;
    errors   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      bmfw_pkg::CFG_DUAL_MODE: dual_mode = val[0];
      bmfw_pkg::CFG_TIMEOUT:   timeout_s = val[7:0];
      bmfw_pkg::CFG_VMAX:      vmax      = val;
      bmfw_pkg::CFG_VMIN:      vmin      = val;
      bmfw_pkg::CFG_TMAX:      tmax      = val;
      bmfw_pkg::CFG_TMIN:      tmin      = val;
      default: ;
    endcase
  endfunction

  function void note_transfer(bmfw_pkg::action_t act, logic [10:0] id, logic [7:0][7:0] pay);
    int u;
    bit valid, allowed;
    bmfw_pkg::result_t r;
    if (act == bmfw_pkg::ACT_FRAME) begin
      if (id == bmfw_pkg::ID_UNIT0) u = 0;
      else if (id == bmfw_pkg::ID_UNIT1) u = 1;
      else return;
      unit_maxc[u] = {pay[0], pay[1]};
      unit_minc[u] = {pay[2], pay[3]};
      unit_maxt[u] = {pay[4], pay[5]};
      unit_mint[u] = {pay[6], pay[7]};
      silence[u]   = 12'(timeout_s * 10);
      if (dual_mode) begin
        agg_minc = (unit_minc[0] < unit_minc[1]) ? unit_minc[0] : unit_minc[1];
        agg_maxc = (unit_maxc[0] > unit_maxc[1]) ? unit_maxc[0] : unit_maxc[1];
        // temperature codes fall as temperature rises
        agg_mint = (unit_mint[0] > unit_mint[1]) ? unit_mint[0] : unit_mint[1];
        agg_maxt = (unit_maxt[0] < unit_maxt[1]) ? unit_maxt[0] : unit_maxt[1];
      end else begin
        agg_minc = unit_minc[0];
        agg_maxc = unit_maxc[0];
        agg_mint = unit_mint[0];
        agg_maxt = unit_maxt[0];
      end
      return;
    end
    for (int i = 0; i < 2; i++)
      if (silence[i] != 0) silence[i] = silence[i] - 1;
    valid   = (silence[0] != 0) && (!dual_mode || silence[1] != 0);
    allowed = valid && agg_maxc <= vmax && agg_minc >= vmin &&
              agg_maxt <= tmax && agg_mint >= tmin;
    r.data_valid     = valid;
    r.charge_allowed = allowed;
    r.charge_limit   = allowed ? bmfw_pkg::CHARGE_LIMIT_ON : '0;
    r.min_cell_out   = valid ? agg_minc : '0;
    r.max_cell_out   = valid ? agg_maxc : '0;
    r.min_temp_out   = valid ? agg_mint : '0;
    r.max_temp_out   = valid ? agg_maxt : '0;
    expected_status.push_back(r);
  endfunction

  function void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  function void check_status(bmfw_pkg::result_t got);
    bmfw_pkg::result_t want;
    if (expected_status.size() == 0) begin
      $error("status transfer with none outstanding: %h", got);
      errors++;
      return;
    end
    want = expected_status.pop_front();
    check_field("data_valid", want.data_valid, got.data_valid);
    check_field("charge_allowed", want.charge_allowed, got.charge_allowed);
    check_field("charge_limit", want.charge_limit, got.charge_limit);
    check_field("min_cell_out", want.min_cell_out, got.min_cell_out);
    check_field("max_cell_out", want.max_cell_out, got.max_cell_out);
    check_field("min_temp_out", want.min_temp_out, got.min_temp_out);
    check_field("max_temp_out", want.max_temp_out, got.max_temp_out);
  endfunction

  function void check_drained();
    if (expected_status.size() != 0) begin
      $error("%0d status transfers never arrived", expected_status.size());
      errors++;
    end
  endfunction
endclass

module tb;
  import bmfw_pkg::*;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;
  // Cycles to let pass after the last outstanding status before touching registers:
  // input register plus result register, with margin.
  localparam int SETTLE_CYCLES = 6;
  // Receiver hold-off long enough to back the pipeline up into in_tready.
  localparam int LONG_HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Set by the stimulus, cleared by the receiver once it starts the hold-off.
  bit long_hold_req = 1'b0;

  status_predictor sb = new();

  battery_monitor_frame_watchdog dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block wedges; far beyond the slowest correct run.
  initial begin
    #800000;
    $display("tb NOT OK");
    $finish;
  end

  // Check every status transfer; values are sampled as they stood before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(result_t'(out_tdata));
  end

  // Receiver: stretches of always-ready, light stalls and heavy stalls, plus a long
  // hold-off on request so ticks pile up behind the result register.
  initial begin
    int mode, len;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 3) != 0);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Big-endian code layout of one frame payload; byte0 lands in pay[0].
  function automatic logic [7:0][7:0] pack_codes(logic [15:0] maxc, logic [15:0] minc,
                                                 logic [15:0] maxt, logic [15:0] mint);
    logic [7:0][7:0] pay;
    pay[0] = maxc[15:8];
    pay[1] = maxc[7:0];
    pay[2] = minc[15:8];
    pay[3] = minc[7:0];
    pay[4] = maxt[15:8];
    pay[5] = maxt[7:0];
    pay[6] = mint[15:8];
    pay[7] = mint[7:0];
    return pay;
  endfunction

  // Mostly codes inside the window so charging is sometimes allowed; sometimes the
  // window edges exactly, sometimes anything at all.
  function automatic logic [15:0] pick_code(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? lo : hi;
      default: return (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the transfer happens; valid stays high on return.
  task automatic send_item(action_t act, logic [10:0] id, logic [7:0][7:0] pay);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W-75){1'b0}}, pay, id};
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(act, id, pay);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 11'($urandom), 64'({$urandom, $urandom}));
  endtask

  // Drop valid and wait until every status is back and the pipeline has emptied.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Load a full register set while idle; a stray write to a spare index rides along.
  task automatic configure(bit dual, logic [7:0] tmo, logic [15:0] vmx, logic [15:0] vmn,
                           logic [15:0] tmx, logic [15:0] tmn);
    wait_idle();
    write_reg(CFG_DUAL_MODE, {15'd0, dual});
    write_reg(CFG_TIMEOUT, {8'd0, tmo});
    write_reg(CFG_VMAX, vmx);
    write_reg(CFG_VMIN, vmn);
    write_reg(CFG_TMAX, tmx);
    write_reg(CFG_TMIN, tmn);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic in bursts. Every so often one unit goes quiet for a while so its
  // silence counter can run out. Noise frames do not count toward n_items.
  task automatic run_phase(int n_items);
    int sent, burst, gap, mute, r, u;
    logic [10:0] id;
    sent = 0;
    mute = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent % 40 == 0) mute = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_tick();
          sent++;
        end else if (r < 90) begin
          u = $urandom_range(0, 1);
          if (mute == 1) u = 1;
          if (mute == 2) u = 0;
          id = u ? ID_UNIT1 : ID_UNIT0;
          send_item(ACT_FRAME, id,
                    pack_codes(pick_code(sb.vmin, sb.vmax), pick_code(sb.vmin, sb.vmax),
                               pick_code(sb.tmin, sb.tmax), pick_code(sb.tmin, sb.tmax)));
          sent++;
        end else begin
          send_item(ACT_FRAME, 11'($urandom), 64'({$urandom, $urandom}));
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [15:0] lo, hi;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, single unit, reload of ten ticks.
    send_tick();                                              // silent since reset
    send_item(ACT_FRAME, ID_UNIT0, pack_codes(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_tick();                                              // below vmin
    send_item(ACT_FRAME, ID_UNIT0, pack_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_tick();                                              // above vmax
    send_item(ACT_FRAME, ID_UNIT0, pack_codes(16'd50000, 16'd40000, 16'd30000, 16'd20000));
    send_tick();                                              // inside every limit
    send_item(ACT_FRAME, ID_UNIT1, pack_codes(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    send_tick();                                              // single mode ignores unit 1
    // Unknown identifiers, including neighbors of the unit ids, change nothing.
    send_item(ACT_FRAME, 11'h4F0, pack_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(ACT_FRAME, 11'h4F4, pack_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(ACT_FRAME, 11'h7FF, pack_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(ACT_FRAME, 11'h000, pack_codes(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Run the counter down past zero; it must stick there.
    repeat (9) send_tick();

    // Zero timeout in dual mode: a fresh frame leaves the unit silent at once.
    configure(1'b1, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(ACT_FRAME, ID_UNIT0, pack_codes(16'd1000, 16'd900, 16'd800, 16'd700));
    send_item(ACT_FRAME, ID_UNIT1, pack_codes(16'd2000, 16'd100, 16'd300, 16'd900));
    send_tick();

    // Random phases across several register settings; the first opens with a long
    // receiver hold-off while traffic keeps coming.
    configure(1'b0, 8'd1, RST_VMAX, RST_VMIN, RST_TMAX, RST_TMIN);
    long_hold_req = 1'b1;
    run_phase(300);

    lo = 16'($urandom);
    hi = 16'($urandom);
    if (lo > hi) {lo, hi} = {hi, lo};
    configure(1'b1, 8'd2, hi, lo, 16'($urandom_range(65535, 32768)),
              16'($urandom_range(32767, 0)));
    run_phase(300);

    // Wide-open window; everything passes while valid.
    configure(1'b1, 8'd3, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    run_phase(300);

    // Closed window and the longest timeout; charging allowed only on codes exactly at every edge.
    configure(1'b0, 8'd255, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    long_hold_req = 1'b1;
    run_phase(300);

    configure(1'b1, 8'd1, RST_VMAX, RST_VMIN, 16'($urandom), 16'($urandom));
    run_phase(300);

    configure(1'b0, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    run_phase(100);

    configure(1'b1, 8'($urandom_range(1, 6)), RST_VMAX, RST_VMIN, RST_TMAX, RST_TMIN);
    run_phase(200);

    // Drain, then give stray results a chance to show up.
    wait_idle();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/bmfw_pkg.sv
design/bmfw_cfg_regs.sv
design/bmfw_in_stage.sv
design/bmfw_core.sv
design/bmfw_out_stage.sv
design/battery_monitor_frame_watchdog.sv
dv/tb.sv
